// File: rtl/bft_pkg.sv
`default_nettype none

package bft_pkg;

	// Grid and field widths.
	localparam int MAX_SLICES  = 64;
	localparam int N_W         = $clog2(MAX_SLICES + 1);
	localparam int SIZE_W      = 16;
	localparam int COORD_W     = 16;
	localparam int IDX_W       = 6;
	localparam int SLICE_CNT_W = 7;

	// Restoring divider layout: the product k*size is divided by the slice count.
	localparam int P_W        = SIZE_W + N_W;
	localparam int STEPS      = 6;
	localparam int DIV_STAGES = (P_W + STEPS - 1) / STEPS;
	localparam int DIV_W      = DIV_STAGES * STEPS;
	localparam int LANES      = 6;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SLICE_COUNT = 2'd3;

	typedef struct packed {
		logic [SIZE_W-1:0] size_x;
		logic [SIZE_W-1:0] size_y;
		logic [SIZE_W-1:0] size_z;
		logic [N_W-1:0]    slices;
	} cfg_t;

	// One divider lane: dq holds the unconsumed dividend bits on top and the
	// quotient bits shifted in at the bottom.
	typedef struct packed {
		logic [DIV_W-1:0] dq;
		logic [N_W-1:0]   rem;
	} div_lane_t;

	typedef struct packed {
		logic                       err;
		logic                       cmd;
		div_lane_t [LANES-1:0]      lane;
	} pipe_t;

	// Finished coordinates of one cell.
	typedef struct packed {
		logic               err;
		logic               cmd;
		logic [COORD_W-1:0] ua0;
		logic [COORD_W-1:0] ua1;
		logic [COORD_W-1:0] vb0;
		logic [COORD_W-1:0] vb1;
		logic [COORD_W-1:0] wc0;
		logic [COORD_W-1:0] wc1;
		logic [COORD_W-1:0] pa_pos;
		logic [COORD_W-1:0] pa_neg;
		logic [COORD_W-1:0] pb_pos;
		logic [COORD_W-1:0] pb_neg;
	} coord_t;

endpackage

`default_nettype wire

// File: rtl/bft_ifs.sv
`default_nettype none

interface bft_req_if;
	import bft_pkg::*;
	logic             valid;
	logic             ready;
	logic             cmd;
	logic [IDX_W-1:0] index_u;
	logic [IDX_W-1:0] index_v;
	modport source (output valid, output cmd, output index_u, output index_v, input ready);
	modport sink (input valid, input cmd, input index_u, input index_v, output ready);
endinterface

interface bft_vtx_if;
	import bft_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] vertex_x;
	logic signed [COORD_W-1:0] vertex_y;
	logic signed [COORD_W-1:0] vertex_z;
	logic                      last;
	logic                      index_error;
	modport source (output valid, output vertex_x, output vertex_y, output vertex_z,
		output last, output index_error, input ready);
	modport sink (input valid, input vertex_x, input vertex_y, input vertex_z,
		input last, input index_error, output ready);
endinterface

interface bft_cfg_if;
	import bft_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/bft_prep.sv
`default_nettype none

module bft_prep (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire bft_pkg::cfg_t cfg,
	bft_req_if.sink            req,
	output logic               out_valid,
	input  wire logic          out_ready,
	output bft_pkg::pipe_t     out_item
);
	import bft_pkg::*;

	logic  vld_s1;
	pipe_t item_s1;
	pipe_t nxt;
	logic  stage_ready;

	function automatic logic [DIV_W-1:0] prod(logic [N_W-1:0] k, logic [SIZE_W-1:0] s);
		logic [P_W-1:0] p;
		p = {{(P_W-N_W){1'b0}}, k} * {{N_W{1'b0}}, s};
		return DIV_W'(p);
	endfunction

	always_comb begin
		logic [N_W-1:0]    u0;
		logic [N_W-1:0]    v0;
		logic [SIZE_W-1:0] sa;
		logic [SIZE_W-1:0] sb;
		u0 = N_W'(req.index_u);
		v0 = N_W'(req.index_v);
		sa = req.cmd ? cfg.size_y : cfg.size_x;
		sb = req.cmd ? cfg.size_z : cfg.size_y;
		nxt.err = (u0 >= cfg.slices) || (v0 >= cfg.slices);
		nxt.cmd = req.cmd;
		nxt.lane[0].dq = prod(u0, sa);
		nxt.lane[1].dq = prod(u0 + N_W'(1), sa);
		nxt.lane[2].dq = prod(v0, sb);
		nxt.lane[3].dq = prod(v0 + N_W'(1), sb);
		nxt.lane[4].dq = prod(v0, cfg.size_z);
		nxt.lane[5].dq = prod(v0 + N_W'(1), cfg.size_z);
		for (int l = 0; l < LANES; l++) begin
			nxt.lane[l].rem = '0;
		end
	end

	assign stage_ready = !vld_s1 || out_ready;
	assign req.ready   = stage_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (stage_ready) begin
			vld_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stage_ready && req.valid) begin
			item_s1 <= nxt;
		end
	end

	assign out_valid = vld_s1;
	assign out_item  = item_s1;

endmodule

`default_nettype wire

// File: rtl/bft_div_stage.sv
`default_nettype none

module bft_div_stage (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire bft_pkg::cfg_t  cfg,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire bft_pkg::pipe_t in_item,
	output logic                out_valid,
	input  wire logic           out_ready,
	output bft_pkg::pipe_t      out_item
);
	import bft_pkg::*;

	logic  vld_sdiv;
	pipe_t item_sdiv;
	pipe_t nxt;

	// Several restoring steps per lane; with a nonzero slice count the remainder
	// stays below it, so it fits in N_W bits.
	always_comb begin
		logic [N_W:0] trial;
		nxt = in_item;
		for (int l = 0; l < LANES; l++) begin
			for (int st = 0; st < STEPS; st++) begin
				trial = {nxt.lane[l].rem, nxt.lane[l].dq[DIV_W-1]};
				if (trial >= {1'b0, cfg.slices}) begin
					nxt.lane[l].rem = N_W'(trial - {1'b0, cfg.slices});
					nxt.lane[l].dq  = {nxt.lane[l].dq[DIV_W-2:0], 1'b1};
				end else begin
					nxt.lane[l].rem = trial[N_W-1:0];
					nxt.lane[l].dq  = {nxt.lane[l].dq[DIV_W-2:0], 1'b0};
				end
			end
		end
	end

	assign in_ready = !vld_sdiv || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sdiv <= 1'b0;
		end else if (in_ready) begin
			vld_sdiv <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_sdiv <= nxt;
		end
	end

	assign out_valid = vld_sdiv;
	assign out_item  = item_sdiv;

endmodule

`default_nettype wire

// File: rtl/bft_finish.sv
`default_nettype none

module bft_finish (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire bft_pkg::cfg_t  cfg,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire bft_pkg::pipe_t in_item,
	output logic                out_valid,
	input  wire logic           out_ready,
	output bft_pkg::coord_t     out_set
);
	import bft_pkg::*;

	logic   vld_s6;
	coord_t set_s6;
	coord_t nxt;

	// Quotient minus half the size, clipped at the top of the signed range.
	function automatic logic [COORD_W-1:0] to_coord(logic [SIZE_W-1:0] q,
		logic [SIZE_W-1:0] s);
		logic signed [SIZE_W+1:0] d;
		d = $signed({2'b00, q}) - $signed({3'b000, s[SIZE_W-1:1]});
		if (d > $signed((SIZE_W+2)'(32767))) begin
			return COORD_W'(32767);
		end
		return d[COORD_W-1:0];
	endfunction

	always_comb begin
		logic [SIZE_W-1:0] sa;
		logic [SIZE_W-1:0] sb;
		logic [SIZE_W-1:0] pa;
		sa = in_item.cmd ? cfg.size_y : cfg.size_x;
		sb = in_item.cmd ? cfg.size_z : cfg.size_y;
		pa = in_item.cmd ? cfg.size_x : cfg.size_y;
		nxt.err    = in_item.err;
		nxt.cmd    = in_item.cmd;
		nxt.ua0    = to_coord(in_item.lane[0].dq[SIZE_W-1:0], sa);
		nxt.ua1    = to_coord(in_item.lane[1].dq[SIZE_W-1:0], sa);
		nxt.vb0    = to_coord(in_item.lane[2].dq[SIZE_W-1:0], sb);
		nxt.vb1    = to_coord(in_item.lane[3].dq[SIZE_W-1:0], sb);
		nxt.wc0    = to_coord(in_item.lane[4].dq[SIZE_W-1:0], cfg.size_z);
		nxt.wc1    = to_coord(in_item.lane[5].dq[SIZE_W-1:0], cfg.size_z);
		nxt.pa_pos = to_coord(pa, pa);
		nxt.pa_neg = to_coord('0, pa);
		nxt.pb_pos = to_coord(cfg.size_z, cfg.size_z);
		nxt.pb_neg = to_coord('0, cfg.size_z);
	end

	assign in_ready = !vld_s6 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (in_ready) begin
			vld_s6 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			set_s6 <= nxt;
		end
	end

	assign out_valid = vld_s6;
	assign out_set   = set_s6;

endmodule

`default_nettype wire

// File: rtl/bft_emit.sv
`default_nettype none

module bft_emit (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire bft_pkg::coord_t in_set,
	bft_vtx_if.source            vtx
);
	import bft_pkg::*;

	localparam logic [2:0] FACE_TOP    = 3'd0;
	localparam logic [2:0] FACE_BOTTOM = 3'd1;
	localparam logic [2:0] FACE_FRONT  = 3'd2;
	localparam logic [2:0] FACE_BACK   = 3'd3;
	localparam logic [2:0] FACE_LEFT   = 3'd4;
	localparam logic [2:0] FACE_RIGHT  = 3'd5;
	localparam logic [2:0] CORNER_LAST = 3'd5;

	// Corner c sits in bits [2c+1:2c] as {first axis select, second axis select}.
	localparam logic [11:0] PAT_TOP    = 12'b10_11_00_11_01_00;
	localparam logic [11:0] PAT_BOTTOM = 12'b11_10_00_01_11_00;
	localparam logic [11:0] PAT_FRONT  = 12'b01_11_00_11_10_00;
	localparam logic [11:0] PAT_BACK   = 12'b11_01_00_10_11_00;
	localparam logic [11:0] PAT_LEFT   = 12'b10_11_01_10_01_00;
	localparam logic [11:0] PAT_RIGHT  = 12'b11_10_01_01_10_00;

	logic               busy_q;
	logic [2:0]         face_q;
	logic [2:0]         corner_q;
	coord_t             set_q;
	logic [11:0]        pat;
	logic               sel_a;
	logic               sel_b;
	logic               is_last;
	logic               xfer;
	logic [COORD_W-1:0] vx;
	logic [COORD_W-1:0] vy;
	logic [COORD_W-1:0] vz;

	assign is_last = set_q.err ||
		((corner_q == CORNER_LAST) && ((face_q == FACE_BACK) || (face_q == FACE_RIGHT)));
	assign xfer     = busy_q && vtx.ready;
	assign in_ready = !busy_q || (xfer && is_last);

	always_comb begin
		unique case (face_q)
			FACE_TOP:    pat = PAT_TOP;
			FACE_BOTTOM: pat = PAT_BOTTOM;
			FACE_FRONT:  pat = PAT_FRONT;
			FACE_BACK:   pat = PAT_BACK;
			FACE_LEFT:   pat = PAT_LEFT;
			default:     pat = PAT_RIGHT;
		endcase
		sel_a = pat[{corner_q, 1'b1}];
		sel_b = pat[{corner_q, 1'b0}];
		unique case (face_q)
			FACE_TOP, FACE_BOTTOM: begin
				vx = sel_a ? set_q.ua1 : set_q.ua0;
				vy = (face_q == FACE_TOP) ? set_q.pa_pos : set_q.pa_neg;
				vz = sel_b ? set_q.wc1 : set_q.wc0;
			end
			FACE_FRONT, FACE_BACK: begin
				vx = sel_a ? set_q.ua1 : set_q.ua0;
				vy = sel_b ? set_q.vb1 : set_q.vb0;
				vz = (face_q == FACE_FRONT) ? set_q.pb_pos : set_q.pb_neg;
			end
			default: begin
				vx = (face_q == FACE_RIGHT) ? set_q.pa_pos : set_q.pa_neg;
				vy = sel_a ? set_q.ua1 : set_q.ua0;
				vz = sel_b ? set_q.vb1 : set_q.vb0;
			end
		endcase
		if (set_q.err) begin
			vx = '0;
			vy = '0;
			vz = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			face_q   <= FACE_TOP;
			corner_q <= '0;
		end else if (in_ready) begin
			busy_q   <= in_valid;
			face_q   <= in_set.cmd ? FACE_LEFT : FACE_TOP;
			corner_q <= '0;
		end else if (xfer) begin
			if (corner_q == CORNER_LAST) begin
				corner_q <= '0;
				face_q   <= face_q + 3'd1;
			end else begin
				corner_q <= corner_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			set_q <= in_set;
		end
	end

	assign vtx.valid       = busy_q;
	assign vtx.vertex_x    = $signed(vx);
	assign vtx.vertex_y    = $signed(vy);
	assign vtx.vertex_z    = $signed(vz);
	assign vtx.last        = is_last;
	assign vtx.index_error = set_q.err;

`ifndef SYNTH
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !vtx.ready |=> busy_q && $stable(face_q) && $stable(corner_q))
		else $error("vertex sequence moved while the output was stalled");

	a_corner_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (corner_q <= CORNER_LAST) && (face_q <= FACE_RIGHT))
		else $error("vertex counter out of range");

	a_side_faces: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && set_q.cmd && !set_q.err |-> (face_q == FACE_LEFT) || (face_q == FACE_RIGHT))
		else $error("left/right cell visited a top/bottom/front/back face");

	a_error_single: assert property (@(posedge clk) disable iff (!arst_n)
		vtx.valid && vtx.index_error |-> vtx.last)
		else $error("error result not marked last");
`endif

endmodule

`default_nettype wire

// File: rtl/box_face_tessellator.sv
// Channel  Modport  Transfer moves                            Handshake
// req      sink     cmd, index_u, index_v (one grid cell)     valid/ready
// vtx      source   vertex_x/y/z, last, index_error           valid/ready
// cfg      sink     index, data (register write)              valid/ready, ready held high
//
// A cell reaches the vertex sequencer through one product stage, DIV_STAGES
// restoring divider stages and one offset stage. The sequencer then drives
// 24 vertices for a top/bottom/front/back cell, 12 for a left/right cell and
// one for an out-of-range cell, one per cycle while vtx is ready; that output
// run sets the sustained rate. Reset clears every valid bit and sets the sizes to
// 256 and the slice count to 1. A stall on vtx holds the current vertex and
// backs up the pipeline stage by stage without loss or repetition.
`default_nettype none

module box_face_tessellator (
	input  wire logic clk,
	input  wire logic arst_n,
	bft_req_if.sink   req,
	bft_vtx_if.source vtx,
	bft_cfg_if.sink   cfg
);
	import bft_pkg::*;

	// Configuration registers. Writes must arrive only while the block is idle; the
	// block does not enforce this. Every stage reads the live values, not a copy.
	logic [SIZE_W-1:0]      size_x_q;
	logic [SIZE_W-1:0]      size_y_q;
	logic [SIZE_W-1:0]      size_z_q;
	logic [SLICE_CNT_W-1:0] slice_count_q;
	cfg_t                   cfg_live;

	// Pipeline links: entry 0 is the product stage output, the last entry the
	// final divider stage output.
	pipe_t                 div_item [DIV_STAGES+1];
	logic [DIV_STAGES:0]   div_valid;
	logic [DIV_STAGES:0]   div_ready;

	logic   fin_valid;
	logic   fin_ready;
	coord_t fin_set;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q      <= SIZE_W'(256);
			size_y_q      <= SIZE_W'(256);
			size_z_q      <= SIZE_W'(256);
			slice_count_q <= SLICE_CNT_W'(1);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_SIZE_X:      size_x_q      <= cfg.data[SIZE_W-1:0];
				CFG_SIZE_Y:      size_y_q      <= cfg.data[SIZE_W-1:0];
				CFG_SIZE_Z:      size_z_q      <= cfg.data[SIZE_W-1:0];
				CFG_SLICE_COUNT: slice_count_q <= cfg.data[SLICE_CNT_W-1:0];
			endcase
		end
	end

	// Slice counts above the grid limit saturate. A zero count makes every
	// index fail the range check, so the divider result is never used.
	always_comb begin
		cfg_live.size_x = size_x_q;
		cfg_live.size_y = size_y_q;
		cfg_live.size_z = size_z_q;
		if (32'(slice_count_q) > MAX_SLICES) begin
			cfg_live.slices = N_W'(MAX_SLICES);
		end else begin
			cfg_live.slices = N_W'(slice_count_q);
		end
	end

	bft_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_live),
		.req       (req),
		.out_valid (div_valid[0]),
		.out_ready (div_ready[0]),
		.out_item  (div_item[0])
	);

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		bft_div_stage u_div (
			.clk       (clk),
			.arst_n    (arst_n),
			.cfg       (cfg_live),
			.in_valid  (div_valid[g]),
			.in_ready  (div_ready[g]),
			.in_item   (div_item[g]),
			.out_valid (div_valid[g+1]),
			.out_ready (div_ready[g+1]),
			.out_item  (div_item[g+1])
		);
	end

	// The quotient is at most the size itself, since the cell index plus one
	// never exceeds the slice count for a valid cell.
	bft_finish u_finish (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_live),
		.in_valid  (div_valid[DIV_STAGES]),
		.in_ready  (div_ready[DIV_STAGES]),
		.in_item   (div_item[DIV_STAGES]),
		.out_valid (fin_valid),
		.out_ready (fin_ready),
		.out_set   (fin_set)
	);

	// The sequencer walks the faces in a fixed corner order and takes the next
	// cell as soon as the last vertex of the current one transfers.
	bft_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (fin_valid),
		.in_ready (fin_ready),
		.in_set   (fin_set),
		.vtx      (vtx)
	);

endmodule

`default_nettype wire

// File: test/box_face_tessellator_tb.sv
`default_nettype none

module box_face_tessellator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bft_pkg::*;

	localparam int CLK_PERIOD   = 10;
	localparam int RANDOM_ITEMS = 100;
	// Cycles allowed after the last expected vertex for stray output to show up.
	localparam int DRAIN_CYCLES = 32;
	// Far above the slowest correct run: about 130 cells of 24 vertices, each
	// vertex waiting out the longest receiver stall run.
	localparam int TIMEOUT_NS   = 4_000_000;

	// Cell commands carried in the cmd field of a request transfer.
	localparam logic CMD_TBFB = 1'b0;	// top, bottom, front and back faces
	localparam logic CMD_LR   = 1'b1;	// left and right faces

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		logic                      last;
		logic                      err;
	} vertex_t;

	// One full register setting, written in index order.
	typedef struct packed {
		logic [CFG_DATA_W-1:0] sx;
		logic [CFG_DATA_W-1:0] sy;
		logic [CFG_DATA_W-1:0] sz;
		logic [CFG_DATA_W-1:0] sc;
	} reg_set_t;

	typedef enum logic {ROW_CFG, ROW_CELL} row_kind_t;

	// A directed row is either a register setting or a cell. A cell row may
	// carry the first vertex of its run typed in by hand; that vertex then
	// stands in for the predicted one.
	typedef struct packed {
		row_kind_t        kind;
		logic             cmd;
		logic [IDX_W-1:0] u;
		logic [IDX_W-1:0] v;
		reg_set_t         regs;
		logic             known;
		vertex_t          first;
	} stim_row_t;

	typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_BURSTY} stall_mode_t;

	localparam reg_set_t NO_REGS = '0;
	localparam vertex_t  NO_VTX  = '0;
	localparam vertex_t  ERR_VTX = '{16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1};

	localparam int NUM_ROWS = 30;

	stim_row_t stim_tab [NUM_ROWS] = '{
		// Reset setting: unit cube, one cell per edge, so the grid is -0.5 and +0.5.
		'{ROW_CELL, CMD_TBFB, 6'd0, 6'd0, NO_REGS, 1'b1,
			'{-16'sd128, 16'sd128, -16'sd128, 1'b0, 1'b0}},
		'{ROW_CELL, CMD_LR, 6'd0, 6'd0, NO_REGS, 1'b1,
			'{-16'sd128, -16'sd128, -16'sd128, 1'b0, 1'b0}},
		// Indices at and beyond the slice count give the lone error vertex.
		'{ROW_CELL, CMD_TBFB, 6'd1, 6'd0, NO_REGS, 1'b1, ERR_VTX},
		'{ROW_CELL, CMD_LR, 6'd0, 6'd63, NO_REGS, 1'b1, ERR_VTX},
		'{ROW_CELL, CMD_LR, 6'd63, 6'd63, NO_REGS, 1'b1, ERR_VTX},
		// Largest box: the positive face lands on +32768 and saturates.
		'{ROW_CFG, CMD_TBFB, 6'd0, 6'd0, '{16'd65535, 16'd65535, 16'd65535, 16'd1}, 1'b0, NO_VTX},
		'{ROW_CELL, CMD_TBFB, 6'd0, 6'd0, NO_REGS, 1'b1,
			'{-16'sd32767, 16'sd32767, -16'sd32767, 1'b0, 1'b0}},
		'{ROW_CELL, CMD_LR, 6'd0, 6'd0, NO_REGS, 1'b1,
			'{-16'sd32767, -16'sd32767, -16'sd32767, 1'b0, 1'b0}},
		// Empty box at the full slice count: every coordinate is zero.
		'{ROW_CFG, CMD_TBFB, 6'd0, 6'd0, '{16'd0, 16'd0, 16'd0, 16'd64}, 1'b0, NO_VTX},
		'{ROW_CELL, CMD_TBFB, 6'd63, 6'd63, NO_REGS, 1'b1, NO_VTX},
		'{ROW_CELL, CMD_LR, 6'd63, 6'd0, NO_REGS, 1'b1, NO_VTX},
		// Uneven sizes at the full slice count.
		'{ROW_CFG, CMD_TBFB, 6'd0, 6'd0, '{16'd256, 16'd512, 16'd1024, 16'd64}, 1'b0, NO_VTX},
		'{ROW_CELL, CMD_TBFB, 6'd0, 6'd63, NO_REGS, 1'b0, NO_VTX},
		'{ROW_CELL, CMD_LR, 6'd63, 6'd0, NO_REGS, 1'b0, NO_VTX},
		'{ROW_CELL, CMD_TBFB, 6'd31, 6'd32, NO_REGS, 1'b0, NO_VTX},
		'{ROW_CELL, CMD_LR, 6'd17, 6'd42, NO_REGS, 1'b0, NO_VTX},
		// A zero slice count turns every cell into an error.
		'{ROW_CFG, CMD_TBFB, 6'd0, 6'd0, '{16'd1000, 16'd3, 16'd777, 16'd0}, 1'b0, NO_VTX},
		'{ROW_CELL, CMD_TBFB, 6'd0, 6'd0, NO_REGS, 1'b1, ERR_VTX},
		'{ROW_CELL, CMD_LR, 6'd0, 6'd0, NO_REGS, 1'b1, ERR_VTX},
		// A slice count above the maximum behaves as the maximum.
		'{ROW_CFG, CMD_TBFB, 6'd0, 6'd0, '{16'd256, 16'd256, 16'd256, 16'd100}, 1'b0, NO_VTX},
		'{ROW_CELL, CMD_TBFB, 6'd63, 6'd63, NO_REGS, 1'b0, NO_VTX},
		'{ROW_CELL, CMD_LR, 6'd0, 6'd63, NO_REGS, 1'b0, NO_VTX},
		// Three slices with sizes that leave a remainder in the division.
		'{ROW_CFG, CMD_TBFB, 6'd0, 6'd0, '{16'd12345, 16'd54321, 16'd40000, 16'd3}, 1'b0, NO_VTX},
		'{ROW_CELL, CMD_TBFB, 6'd2, 6'd2, NO_REGS, 1'b0, NO_VTX},
		'{ROW_CELL, CMD_TBFB, 6'd3, 6'd0, NO_REGS, 1'b1, ERR_VTX},
		'{ROW_CELL, CMD_LR, 6'd0, 6'd3, NO_REGS, 1'b1, ERR_VTX},
		'{ROW_CELL, CMD_LR, 6'd2, 6'd1, NO_REGS, 1'b0, NO_VTX},
		// Largest register value, saturated, with a very thin box.
		'{ROW_CFG, CMD_TBFB, 6'd0, 6'd0, '{16'd65535, 16'd1, 16'd2, 16'd127}, 1'b0, NO_VTX},
		'{ROW_CELL, CMD_TBFB, 6'd63, 6'd0, NO_REGS, 1'b0, NO_VTX},
		'{ROW_CELL, CMD_LR, 6'd0, 6'd63, NO_REGS, 1'b0, NO_VTX}
	};

	logic clk = 1'b0;
	logic arst_n;

	bft_req_if req_if();
	bft_vtx_if vtx_if();
	bft_cfg_if cfg_if();

	box_face_tessellator DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.vtx    (vtx_if),
		.cfg    (cfg_if)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Predictor copy of the configuration registers.
	logic [SIZE_W-1:0]      box_sx;
	logic [SIZE_W-1:0]      box_sy;
	logic [SIZE_W-1:0]      box_sz;
	logic [SLICE_CNT_W-1:0] slice_reg;

	// Vertices predicted for accepted cells, oldest first.
	vertex_t pending_vertices [$];

	int fail_count = 0;
	int vertex_count = 0;
	vertex_t got_vtx;
	vertex_t want_vtx;

	// A write to the slice count keeps only the register's width, as the
	// block does.
	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			CFG_SIZE_X:      box_sx = data;
			CFG_SIZE_Y:      box_sy = data;
			CFG_SIZE_Z:      box_sz = data;
			CFG_SLICE_COUNT: slice_reg = data[SLICE_CNT_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] reg_value(reg_set_t r, logic [CFG_IDX_W-1:0] idx);
		case (idx)
			CFG_SIZE_X:      return r.sx;
			CFG_SIZE_Y:      return r.sy;
			CFG_SIZE_Z:      return r.sz;
			default:         return r.sc;
		endcase
	endfunction

	// Slice counts above the maximum saturate to it.
	function automatic int unsigned live_slices();
		return (slice_reg > MAX_SLICES) ? MAX_SLICES : slice_reg;
	endfunction

	// Grid line k of n on an axis of size s: floor(k*s/n) - floor(s/2), with
	// both ends clipped to the smallest and largest signed Q8.8 values.
	function automatic logic signed [COORD_W-1:0] grid_line(int unsigned s, int unsigned k,
		int unsigned n);
		longint g;
		g = longint'((k * s) / n) - longint'(s >> 1);
		if (g > 32767)
			g = 32767;
		if (g < -32768)
			g = -32768;
		return g[COORD_W-1:0];
	endfunction

	// Builds the whole vertex run of one cell under the current registers.
	function automatic void tessellate_cell(logic cmd, logic [IDX_W-1:0] u,
		logic [IDX_W-1:0] v, output vertex_t run [$]);
		int unsigned n;
		logic signed [COORD_W-1:0] x0, x1, y0, y1, z0, z1;
		logic signed [COORD_W-1:0] xp, xn, yp, yn, zp, zn;
		n = live_slices();
		run = {};
		if (n == 0 || u >= n || v >= n) begin
			run.push_back(ERR_VTX);
			return;
		end
		xp = grid_line(box_sx, n, n);
		xn = grid_line(box_sx, 0, n);
		yp = grid_line(box_sy, n, n);
		yn = grid_line(box_sy, 0, n);
		zp = grid_line(box_sz, n, n);
		zn = grid_line(box_sz, 0, n);
		if (cmd == CMD_TBFB) begin
			// u walks x; v walks both y and z.
			x0 = grid_line(box_sx, u, n);
			x1 = grid_line(box_sx, u + 1, n);
			y0 = grid_line(box_sy, v, n);
			y1 = grid_line(box_sy, v + 1, n);
			z0 = grid_line(box_sz, v, n);
			z1 = grid_line(box_sz, v + 1, n);
			// Top face.
			run.push_back('{x0, yp, z0, 1'b0, 1'b0});
			run.push_back('{x0, yp, z1, 1'b0, 1'b0});
			run.push_back('{x1, yp, z1, 1'b0, 1'b0});
			run.push_back('{x0, yp, z0, 1'b0, 1'b0});
			run.push_back('{x1, yp, z1, 1'b0, 1'b0});
			run.push_back('{x1, yp, z0, 1'b0, 1'b0});
			// Bottom face.
			run.push_back('{x0, yn, z0, 1'b0, 1'b0});
			run.push_back('{x1, yn, z1, 1'b0, 1'b0});
			run.push_back('{x0, yn, z1, 1'b0, 1'b0});
			run.push_back('{x0, yn, z0, 1'b0, 1'b0});
			run.push_back('{x1, yn, z0, 1'b0, 1'b0});
			run.push_back('{x1, yn, z1, 1'b0, 1'b0});
			// Front face.
			run.push_back('{x0, y0, zp, 1'b0, 1'b0});
			run.push_back('{x1, y0, zp, 1'b0, 1'b0});
			run.push_back('{x1, y1, zp, 1'b0, 1'b0});
			run.push_back('{x0, y0, zp, 1'b0, 1'b0});
			run.push_back('{x1, y1, zp, 1'b0, 1'b0});
			run.push_back('{x0, y1, zp, 1'b0, 1'b0});
			// Back face.
			run.push_back('{x0, y0, zn, 1'b0, 1'b0});
			run.push_back('{x1, y1, zn, 1'b0, 1'b0});
			run.push_back('{x1, y0, zn, 1'b0, 1'b0});
			run.push_back('{x0, y0, zn, 1'b0, 1'b0});
			run.push_back('{x0, y1, zn, 1'b0, 1'b0});
			run.push_back('{x1, y1, zn, 1'b0, 1'b0});
		end else begin
			// u walks y; v walks z.
			y0 = grid_line(box_sy, u, n);
			y1 = grid_line(box_sy, u + 1, n);
			z0 = grid_line(box_sz, v, n);
			z1 = grid_line(box_sz, v + 1, n);
			// Left face.
			run.push_back('{xn, y0, z0, 1'b0, 1'b0});
			run.push_back('{xn, y0, z1, 1'b0, 1'b0});
			run.push_back('{xn, y1, z0, 1'b0, 1'b0});
			run.push_back('{xn, y0, z1, 1'b0, 1'b0});
			run.push_back('{xn, y1, z1, 1'b0, 1'b0});
			run.push_back('{xn, y1, z0, 1'b0, 1'b0});
			// Right face.
			run.push_back('{xp, y0, z0, 1'b0, 1'b0});
			run.push_back('{xp, y1, z0, 1'b0, 1'b0});
			run.push_back('{xp, y0, z1, 1'b0, 1'b0});
			run.push_back('{xp, y0, z1, 1'b0, 1'b0});
			run.push_back('{xp, y1, z0, 1'b0, 1'b0});
			run.push_back('{xp, y1, z1, 1'b0, 1'b0});
		end
		run[run.size() - 1].last = 1'b1;
	endfunction

	// Sizes lean toward the edges of the range and small boxes, with plain
	// random values in between.
	function automatic logic [SIZE_W-1:0] random_size();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			2, 3:    return SIZE_W'($urandom_range(1, 2048));
			default: return SIZE_W'($urandom);
		endcase
	endfunction

	// Slice counts are mostly small so that most cells stay in range, with
	// zero and saturating values now and then. The data bits above the
	// register width are random; the block has to drop them.
	function automatic reg_set_t random_regs();
		reg_set_t r;
		logic [SLICE_CNT_W-1:0] count;
		r.sx = random_size();
		r.sy = random_size();
		r.sz = random_size();
		case ($urandom_range(0, 9))
			0:          count = '0;
			1:          count = SLICE_CNT_W'($urandom_range(MAX_SLICES + 1, 127));
			2:          count = SLICE_CNT_W'(MAX_SLICES);
			3, 4, 5:    count = SLICE_CNT_W'($urandom_range(1, 4));
			default:    count = SLICE_CNT_W'($urandom_range(1, MAX_SLICES));
		endcase
		r.sc = {(CFG_DATA_W - SLICE_CNT_W)'($urandom), count};
		return r;
	endfunction

	// Most indices fall inside the current grid so that the full vertex runs
	// get exercised; the rest are random over the whole field.
	function automatic logic [IDX_W-1:0] random_index();
		int unsigned n;
		n = live_slices();
		if (n > 0 && $urandom_range(0, 9) < 8)
			return IDX_W'($urandom_range(0, n - 1));
		return IDX_W'($urandom);
	endfunction

	// Presents one cell and holds it until the request transfer. Valid is
	// left high so that a following cell can go out on the next cycle.
	task automatic send_cell(logic cmd, logic [IDX_W-1:0] u, logic [IDX_W-1:0] v,
		logic known, vertex_t first);
		vertex_t run [$];
		req_if.valid   <= 1'b1;
		req_if.cmd     <= cmd;
		req_if.index_u <= u;
		req_if.index_v <= v;
		do @(posedge clk); while (req_if.ready !== 1'b1);
		tessellate_cell(cmd, u, v, run);
		if (known)
			run[0] = first;
		foreach (run[i])
			pending_vertices.push_back(run[i]);
	endtask

	// The sender stops and waits until every predicted vertex has been
	// transferred. Every cell produces at least one vertex, so an empty
	// queue means the block has nothing left in flight.
	task automatic wait_drained();
		req_if.valid <= 1'b0;
		do @(posedge clk); while (pending_vertices.size() != 0);
	endtask

	// Writes all four registers back to back while the block is idle.
	task automatic load_regs(reg_set_t r);
		logic [CFG_IDX_W-1:0] order [4];
		order = '{CFG_SIZE_X, CFG_SIZE_Y, CFG_SIZE_Z, CFG_SLICE_COUNT};
		wait_drained();
		foreach (order[i]) begin
			cfg_if.valid <= 1'b1;
			cfg_if.index <= order[i];
			cfg_if.data  <= reg_value(r, order[i]);
			do @(posedge clk); while (cfg_if.ready !== 1'b1);
			apply_reg(order[i], reg_value(r, order[i]));
		end
		cfg_if.valid <= 1'b0;
	endtask

	task automatic report_field(string name, logic signed [COORD_W-1:0] want,
		logic signed [COORD_W-1:0] got);
		fail_count++;
		$display("%0t: vertex %0d %s expected %0d, got %0d", $time, vertex_count, name,
			want, got);
	endtask

	// Stimulus: reset, the directed table, then random register settings each
	// followed by a burst-shaped stream of random cells.
	initial begin : stimulus
		int sent;
		int phase_items;
		int burst_left;
		int gap;
		bit no_gaps;
		arst_n         <= 1'b0;
		req_if.valid   <= 1'b0;
		req_if.cmd     <= CMD_TBFB;
		req_if.index_u <= '0;
		req_if.index_v <= '0;
		cfg_if.valid   <= 1'b0;
		cfg_if.index   <= CFG_SIZE_X;
		cfg_if.data    <= '0;
		box_sx    = 16'd256;
		box_sy    = 16'd256;
		box_sz    = 16'd256;
		slice_reg = 7'd1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (stim_tab[i]) begin
			if (stim_tab[i].kind == ROW_CFG) begin
				load_regs(stim_tab[i].regs);
			end else begin
				send_cell(stim_tab[i].cmd, stim_tab[i].u, stim_tab[i].v, stim_tab[i].known,
					stim_tab[i].first);
			end
		end

		// Each phase starts with a drained block and a fresh register setting,
		// so the sender also pauses here until every expected vertex is in.
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			load_regs(random_regs());
			phase_items = $urandom_range(8, 20);
			if (phase_items > RANDOM_ITEMS - sent)
				phase_items = RANDOM_ITEMS - sent;
			// Some phases run with the sender never idling.
			no_gaps = ($urandom_range(0, 3) == 0);
			burst_left = $urandom_range(1, 8);
			repeat (phase_items) begin
				send_cell(1'($urandom), random_index(), random_index(), 1'b0, NO_VTX);
				sent++;
				burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 8);
					gap = no_gaps ? 0 : $urandom_range(0, 6);
					if (gap > 0) begin
						req_if.valid <= 1'b0;
						repeat (gap) @(posedge clk);
					end
				end
			end
		end

		wait_drained();
		// Give the block time to push out anything it should not.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("box_face_tessellator_tb: PASS");
		end else begin
			$display("box_face_tessellator_tb: FAIL");
		end
		$finish;
	end

	// Receiver back-pressure: the ready pattern switches, after each random-length
	// interval, between always ready, random stalls, a fixed period and long
	// stall runs, so stalls land on every vertex position of a run.
	initial begin : vertex_stall
		stall_mode_t mode;
		int left;
		int run_left;
		bit hold;
		vtx_if.ready <= 1'b0;
		hold = 1'b0;
		run_left = 0;
		forever begin
			mode = stall_mode_t'($urandom_range(0, 3));
			left = $urandom_range(64, 256);
			while (left > 0) begin
				@(posedge clk);
				left--;
				case (mode)
					STALL_NONE:     vtx_if.ready <= 1'b1;
					STALL_RANDOM:   vtx_if.ready <= ($urandom_range(0, 9) < 7);
					STALL_PERIODIC: vtx_if.ready <= ((left % 5) != 0);
					default: begin
						if (run_left == 0) begin
							hold = ~hold;
							run_left = hold ? $urandom_range(1, 8) : $urandom_range(3, 12);
						end
						run_left--;
						vtx_if.ready <= hold;
					end
				endcase
			end
		end
	end

	// Every vertex transfer is checked against the oldest prediction. Values
	// are sampled at the edge before any of this edge's updates land.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && vtx_if.valid === 1'b1 && vtx_if.ready === 1'b1) begin
			got_vtx = '{vtx_if.vertex_x, vtx_if.vertex_y, vtx_if.vertex_z, vtx_if.last,
				vtx_if.index_error};
			if (pending_vertices.size() == 0) begin
				fail_count++;
				$display("%0t: vertex %0d with nothing expected: x %0d y %0d z %0d last %b err %b",
					$time, vertex_count, got_vtx.x, got_vtx.y, got_vtx.z, got_vtx.last,
					got_vtx.err);
			end else begin
				want_vtx = pending_vertices.pop_front();
				if (got_vtx.x !== want_vtx.x)
					report_field("vertex_x", want_vtx.x, got_vtx.x);
				if (got_vtx.y !== want_vtx.y)
					report_field("vertex_y", want_vtx.y, got_vtx.y);
				if (got_vtx.z !== want_vtx.z)
					report_field("vertex_z", want_vtx.z, got_vtx.z);
				if (got_vtx.last !== want_vtx.last)
					report_field("last", want_vtx.last, got_vtx.last);
				if (got_vtx.err !== want_vtx.err)
					report_field("index_error", want_vtx.err, got_vtx.err);
			end
			vertex_count++;
		end
	end

	// Hard stop in case the block hangs.
	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("box_face_tessellator_tb: FAIL");
		$finish;
	end

endmodule

`default_nettype wire
